[design/fbv_pkg.sv]
// Shared types and constants for the frustum box visibility test.
package fbv_pkg;

    // Field widths of the box request, the plane registers, the configuration index and the result.
    localparam int COORD_W     = 16;
    localparam int HALF_W      = 15;
    localparam int NORM_W      = 16;
    localparam int PLANE_W     = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int VIS_W       = 2;

    // Default plane count and the largest count the index width can address.
    localparam int PLANE_COUNT_DEF = 6;
    localparam int PLANE_COUNT_MAX = 1 << CFG_INDEX_W;

    // Arithmetic widths: signed products, unsigned radius products, accumulator.
    localparam int PROD_W  = COORD_W + NORM_W;
    localparam int RAD_W   = NORM_W + HALF_W;
    localparam int K_SHIFT = 14;
    localparam int ACC_W   = 36;

    // Classification codes on the result channel.
    typedef enum logic [VIS_W-1:0] {
        VIS_INVISIBLE = 2'd0,
        VIS_PARTIAL   = 2'd1,
        VIS_VISIBLE   = 2'd2
    } t_vis;

    // One box as it travels down the row of cells.
    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic        [HALF_W-1:0]  half_x;
        logic        [HALF_W-1:0]  half_y;
        logic        [HALF_W-1:0]  half_z;
    } t_box;

    // Running verdict gathered over the planes seen so far.
    typedef struct packed {
        logic invisible;
        logic partial;
    } t_flags;

    // Configuration write broadcast to every cell.
    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [PLANE_W-1:0]     data;
    } t_cfg_wr;

endpackage

[design/fbv_if.sv]
// Handshake interfaces for the box, result and configuration channels.
interface fbv_box_if
    import fbv_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic        [HALF_W-1:0]  half_x;
    logic        [HALF_W-1:0]  half_y;
    logic        [HALF_W-1:0]  half_z;

    modport source (output valid, center_x, center_y, center_z, half_x, half_y, half_z,
                    input ready);
    modport sink   (input valid, center_x, center_y, center_z, half_x, half_y, half_z,
                    output ready);
endinterface

interface fbv_vis_if
    import fbv_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [VIS_W-1:0] visibility;

    modport source (output valid, visibility, input ready);
    modport sink   (input valid, visibility, output ready);
endinterface

interface fbv_cfg_if
    import fbv_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [PLANE_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/fbv_cell.sv]
// One plane cell: holds a plane register and tests a passing box against it.
module fbv_cell
    import fbv_pkg::*;
#(
    parameter int CELL_INDEX = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_box    i_box,
    input  t_flags  i_flags,
    output logic    o_valid,
    input  logic    i_ready,
    output t_box    o_box,
    output t_flags  o_flags
);

    localparam logic [CFG_INDEX_W-1:0] CellIdx = CFG_INDEX_W'(CELL_INDEX);

    logic [PLANE_W-1:0] r_plane;

    logic signed [NORM_W-1:0]  nx, ny, nz;
    logic signed [COORD_W-1:0] kc;
    logic [NORM_W-1:0]         ax_w, ay_w, az_w;

    logic signed [PROD_W-1:0] n_mx, n_my, n_mz;
    logic        [RAD_W-1:0]  n_rx, n_ry, n_rz;

    logic                     r_a_valid;
    t_box                     r_a_box;
    t_flags                   r_a_flags;
    logic signed [PROD_W-1:0] r_a_mx, r_a_my, r_a_mz;
    logic        [RAD_W-1:0]  r_a_rx, r_a_ry, r_a_rz;
    logic                     a_ready;

    logic signed [ACC_W-1:0] mid, rad, hi, lo, kk;
    t_flags                  n_flags;

    logic   r_b_valid;
    t_box   r_b_box;
    t_flags r_b_flags;
    logic   b_ready;

    // Plane register, written when a configuration request names this cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_cfg.valid && (i_cfg.index == CellIdx)) begin
            r_plane <= i_cfg.data;
        end
    end

    // Unpack the plane fields.
    assign nx = r_plane[15:0];
    assign ny = r_plane[31:16];
    assign nz = r_plane[47:32];
    assign kc = r_plane[63:48];

    // Magnitudes of the normal components; the most negative code maps to 2^15.
    assign ax_w = nx[NORM_W-1] ? (NORM_W'(0) - nx) : nx;
    assign ay_w = ny[NORM_W-1] ? (NORM_W'(0) - ny) : ny;
    assign az_w = nz[NORM_W-1] ? (NORM_W'(0) - nz) : nz;

    // Stage A products: normal times centre, and normal magnitude times half size.
    always_comb begin
        n_mx = $signed({{COORD_W{nx[NORM_W-1]}}, nx})
             * $signed({{NORM_W{i_box.center_x[COORD_W-1]}}, i_box.center_x});
        n_my = $signed({{COORD_W{ny[NORM_W-1]}}, ny})
             * $signed({{NORM_W{i_box.center_y[COORD_W-1]}}, i_box.center_y});
        n_mz = $signed({{COORD_W{nz[NORM_W-1]}}, nz})
             * $signed({{NORM_W{i_box.center_z[COORD_W-1]}}, i_box.center_z});
        n_rx = {{HALF_W{1'b0}}, ax_w} * {{NORM_W{1'b0}}, i_box.half_x};
        n_ry = {{HALF_W{1'b0}}, ay_w} * {{NORM_W{1'b0}}, i_box.half_y};
        n_rz = {{HALF_W{1'b0}}, az_w} * {{NORM_W{1'b0}}, i_box.half_z};
    end

    // A stage moves on when it is empty or the stage after it moves on.
    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // Stage A registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
        if (i_valid && a_ready) begin
            r_a_box   <= i_box;
            r_a_flags <= i_flags;
            r_a_mx    <= n_mx;
            r_a_my    <= n_my;
            r_a_mz    <= n_mz;
            r_a_rx    <= n_rx;
            r_a_ry    <= n_ry;
            r_a_rz    <= n_rz;
        end
    end

    // Stage B: projected interval against the aligned plane constant.
    always_comb begin
        mid = {{(ACC_W-PROD_W){r_a_mx[PROD_W-1]}}, r_a_mx}
            + {{(ACC_W-PROD_W){r_a_my[PROD_W-1]}}, r_a_my}
            + {{(ACC_W-PROD_W){r_a_mz[PROD_W-1]}}, r_a_mz};
        rad = {{(ACC_W-RAD_W){1'b0}}, r_a_rx}
            + {{(ACC_W-RAD_W){1'b0}}, r_a_ry}
            + {{(ACC_W-RAD_W){1'b0}}, r_a_rz};
        kk  = {{(ACC_W-COORD_W-K_SHIFT){kc[COORD_W-1]}}, kc, {K_SHIFT{1'b0}}};
        hi  = mid + rad;
        lo  = mid - rad;
        n_flags.invisible = r_a_flags.invisible || (hi < kk);
        n_flags.partial   = r_a_flags.partial || (lo <= kk);
    end

    // Stage B registers, handed to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
        if (r_a_valid && b_ready) begin
            r_b_box   <= r_a_box;
            r_b_flags <= n_flags;
        end
    end

    assign o_valid = r_b_valid;
    assign o_box   = r_b_box;
    assign o_flags = r_b_flags;

endmodule

[design/frustum_box_visibility_test_top.sv]
// Top level: a row of plane cells that classifies one box per cycle while results are taken.
// Each accepted box request passes the stage A and stage B registers of every cell in turn.
// Throughput: one box per cycle; each cell is a two-stage multiply then add-and-compare step.
// Stages stall only when full and blocked, so the input keeps flowing while a result waits.
// Reset (synchronous, active low) empties the row and clears every plane register to zero,
// which classifies every box as partially visible until the planes are written.
module frustum_box_visibility_test_top
    import fbv_pkg::*;
#(
    parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    fbv_box_if.sink  i_box,
    fbv_vis_if.source o_vis,
    fbv_cfg_if.sink  i_cfg
);

    t_cfg_wr cfg_wr;
    logic    chain_valid [PLANE_COUNT+1];
    logic    chain_ready [PLANE_COUNT+1];
    t_box    chain_box   [PLANE_COUNT+1];
    t_flags  chain_flags [PLANE_COUNT+1];
    t_flags  last_flags;

    // Configuration requests are always taken and broadcast to the cells.
    assign i_cfg.ready  = 1'b1;
    assign cfg_wr.valid = i_cfg.valid;
    assign cfg_wr.index = i_cfg.index;
    assign cfg_wr.data  = i_cfg.data;

    // Head of the row: the incoming box request with a clean verdict.
    assign chain_valid[0]          = i_box.valid;
    assign i_box.ready             = chain_ready[0];
    assign chain_box[0].center_x   = i_box.center_x;
    assign chain_box[0].center_y   = i_box.center_y;
    assign chain_box[0].center_z   = i_box.center_z;
    assign chain_box[0].half_x     = i_box.half_x;
    assign chain_box[0].half_y     = i_box.half_y;
    assign chain_box[0].half_z     = i_box.half_z;
    assign chain_flags[0]          = '0;

    // One cell per plane.
    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
        fbv_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (cfg_wr),
            .i_valid (chain_valid[g]),
            .o_ready (chain_ready[g]),
            .i_box   (chain_box[g]),
            .i_flags (chain_flags[g]),
            .o_valid (chain_valid[g+1]),
            .i_ready (chain_ready[g+1]),
            .o_box   (chain_box[g+1]),
            .o_flags (chain_flags[g+1])
        );
    end

    // Tail of the row: the last cell's register is the output register.
    assign last_flags              = chain_flags[PLANE_COUNT];
    assign o_vis.valid             = chain_valid[PLANE_COUNT];
    assign chain_ready[PLANE_COUNT] = o_vis.ready;

    // Invisible wins over partial; otherwise the box is fully inside.
    always_comb begin
        if (last_flags.invisible) begin
            o_vis.visibility = VIS_INVISIBLE;
        end else if (last_flags.partial) begin
            o_vis.visibility = VIS_PARTIAL;
        end else begin
            o_vis.visibility = VIS_VISIBLE;
        end
    end

endmodule

[design/fbv_checker.sv]
// Port-level checks for the frustum box visibility test, bound to the top level.
module fbv_checker
    import fbv_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_box_valid,
    input logic             i_box_ready,
    input logic             i_vis_valid,
    input logic             i_vis_ready,
    input logic [VIS_W-1:0] i_vis_data,
    input logic             i_cfg_ready
);

    // With the output free to move, the whole row moves and the input is open.
    a_ready_through: assert property (@(posedge i_clk)
        (!i_vis_valid || i_vis_ready) |-> i_box_ready)
        else $error("box input blocked while the output side is free");

    // A stalled result holds its value until it is taken.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vis_valid && !i_vis_ready) |=> (i_vis_valid && $stable(i_vis_data)))
        else $error("result changed or vanished while stalled");

    // The configuration port never back-pressures.
    a_cfg_open: assert property (@(posedge i_clk) i_cfg_ready)
        else $error("configuration port not ready");

    // Reset empties the row: no result on the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk) $past(!i_rst_n) |-> !i_vis_valid)
        else $error("result present right after reset");

    // With no box request, no result can appear on the first cycle out of reset.
    a_no_early_result: assert property (@(posedge i_clk)
        ($past(!i_rst_n) && i_rst_n && !i_box_valid) |=> !i_vis_valid)
        else $error("result appeared without any box request");

endmodule

bind frustum_box_visibility_test_top fbv_checker u_fbv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_box_valid (i_box.valid),
    .i_box_ready (i_box.ready),
    .i_vis_valid (o_vis.valid),
    .i_vis_ready (o_vis.ready),
    .i_vis_data  (o_vis.visibility),
    .i_cfg_ready (i_cfg.ready)
);

[verif/frustum_box_visibility_test_top_tb.sv]
// Self-checking testbench for the frustum box visibility test block.
`timescale 1ns / 100ps

module frustum_box_visibility_test_top_tb
    import fbv_pkg::*;
;

    localparam int PLANES          = PLANE_COUNT_DEF;
    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int REPORT_LIMIT    = 10;

    // Register indexes of the plane registers, the last two lie past the plane count.
    typedef enum logic [CFG_INDEX_W-1:0] {
        PLANE_NEAR   = 3'd0,
        PLANE_FAR    = 3'd1,
        PLANE_LEFT   = 3'd2,
        PLANE_RIGHT  = 3'd3,
        PLANE_BOTTOM = 3'd4,
        PLANE_TOP    = 3'd5,
        PLANE_SPARE6 = 3'd6,
        PLANE_SPARE7 = 3'd7
    } t_plane_idx;

    // Holds a copy of the plane registers and the visibility still owed by the block.
    class vis_scoreboard;
        logic [PLANE_W-1:0] planes [PLANE_COUNT_MAX];
        t_vis               pending_vis [$];
        int                 mismatches;
        int                 results_seen;

        function new();
            foreach (planes[i]) planes[i] = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        // Writes past the plane count are dropped by the block.
        function void write_plane(logic [CFG_INDEX_W-1:0] idx, logic [PLANE_W-1:0] data);
            if (idx < PLANES) planes[idx] = data;
        endfunction

        function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // Projects the box onto every plane normal and combines the verdicts.
        function t_vis classify_box(t_box b);
            logic signed [COORD_W-1:0] cx, cy, cz;
            logic signed [NORM_W-1:0]  nx, ny, nz, cst;
            longint                    mid, rad, bound;
            bit                        invisible, partial;
            invisible = 1'b0;
            partial   = 1'b0;
            cx = b.center_x;
            cy = b.center_y;
            cz = b.center_z;
            for (int p = 0; p < PLANES; p++) begin
                nx  = planes[p][15:0];
                ny  = planes[p][31:16];
                nz  = planes[p][47:32];
                cst = planes[p][63:48];
                mid = longint'(nx) * longint'(cx) + longint'(ny) * longint'(cy)
                    + longint'(nz) * longint'(cz);
                rad = mag(longint'(nx)) * longint'(b.half_x)
                    + mag(longint'(ny)) * longint'(b.half_y)
                    + mag(longint'(nz)) * longint'(b.half_z);
                // The Q12.4 constant is lifted to the Q.18 scale of the products.
                bound = longint'(cst) <<< K_SHIFT;
                if (mid + rad < bound) invisible = 1'b1;
                if (mid - rad <= bound) partial = 1'b1;
            end
            if (invisible) return VIS_INVISIBLE;
            if (partial) return VIS_PARTIAL;
            return VIS_VISIBLE;
        endfunction

        function void note_box(t_box b);
            pending_vis.push_back(classify_box(b));
        endfunction

        function void check_visibility(logic [VIS_W-1:0] got);
            t_vis want;
            if (pending_vis.size() == 0) begin
                if (mismatches < REPORT_LIMIT)
                    $display("Result %0d (visibility %0d) arrived with no box outstanding",
                             results_seen, got);
                mismatches++;
            end else begin
                want = pending_vis.pop_front();
                if (got !== want) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("Result %0d: expected visibility %s (%0d), got %0d",
                                 results_seen, want.name(), want, got);
                    mismatches++;
                end
            end
            results_seen++;
        endfunction

        function int pending();
            return pending_vis.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    fbv_box_if box_if ();
    fbv_vis_if vis_if ();
    fbv_cfg_if cfg_if ();

    vis_scoreboard sb = new();

    int idle_cycles   = 0;
    bit progress;
    bit sender_jitter = 1'b0;
    bit sink_jitter   = 1'b0;
    bit hold_off_req  = 1'b0;

    frustum_box_visibility_test_top #(
        .PLANE_COUNT(PLANES)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_box   (box_if),
        .o_vis   (vis_if),
        .i_cfg   (cfg_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Gap lengths: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PLANE_W-1:0] pack_plane(int nx, int ny, int nz, int cst);
        return {NORM_W'(cst), NORM_W'(nz), NORM_W'(ny), NORM_W'(nx)};
    endfunction

    function automatic t_box mk_box(int cx, int cy, int cz, int hx, int hy, int hz);
        t_box b;
        b.center_x = COORD_W'(cx);
        b.center_y = COORD_W'(cy);
        b.center_z = COORD_W'(cz);
        b.half_x   = HALF_W'(hx);
        b.half_y   = HALF_W'(hy);
        b.half_z   = HALF_W'(hz);
        return b;
    endfunction

    // Offers one box request, after an optional gap, and returns once it is taken.
    task automatic feed_box(input t_box b);
        int gap;
        gap = sender_jitter ? pick_gap() : 0;
        if (gap > 0) begin
            box_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        box_if.valid    <= 1'b1;
        box_if.center_x <= b.center_x;
        box_if.center_y <= b.center_y;
        box_if.center_z <= b.center_z;
        box_if.half_x   <= b.half_x;
        box_if.half_y   <= b.half_y;
        box_if.half_z   <= b.half_z;
        do @(posedge i_clk); while (!box_if.ready);
    endtask

    // Random boxes: noise_pct percent use the full field ranges, the rest lie around the frustum.
    task automatic feed_random(input int count, input int xy_lim, input int z_lo,
                               input int z_hi, input int half_hi, input int noise_pct);
        t_box b;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(1, 100) <= noise_pct) begin
                b.center_x = COORD_W'($urandom);
                b.center_y = COORD_W'($urandom);
                b.center_z = COORD_W'($urandom);
                b.half_x   = HALF_W'($urandom);
                b.half_y   = HALF_W'($urandom);
                b.half_z   = HALF_W'($urandom);
            end else begin
                b = mk_box(int'($urandom_range(0, 2 * xy_lim)) - xy_lim,
                           int'($urandom_range(0, 2 * xy_lim)) - xy_lim,
                           int'($urandom_range(z_lo, z_hi)),
                           $urandom_range(0, half_hi),
                           $urandom_range(0, half_hi),
                           $urandom_range(0, half_hi));
            end
            feed_box(b);
        end
    endtask

    // Extreme coordinates and sizes.
    task automatic feed_extreme_boxes();
        feed_box(mk_box(-32768, -32768, -32768, 0, 0, 0));
        feed_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        feed_box(mk_box(0, 0, 0, 0, 0, 0));
        feed_box(mk_box(-32768, 32767, -32768, 32767, 0, 32767));
    endtask

    // Drops the box valid and waits until every owed result has come back.
    task automatic finish_phase();
        box_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Keeps the write valid high so that writes can follow back to back.
    task automatic write_plane(input t_plane_idx idx, input logic [PLANE_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
    endtask

    task automatic close_config();
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result sink: random stalls, plus a long hold-off on request.
    initial begin : result_sink
        int stall_left;
        stall_left   = 0;
        vis_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end else if (stall_left == 0 && sink_jitter && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                vis_if.ready <= 1'b0;
                stall_left--;
            end else begin
                vis_if.ready <= 1'b1;
            end
        end
    end

    // Monitor: every handshake updates the scoreboard and feeds the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            progress = 1'b0;
            if (cfg_if.valid && cfg_if.ready) begin
                sb.write_plane(cfg_if.index, cfg_if.data);
                progress = 1'b1;
            end
            if (box_if.valid && box_if.ready) begin
                sb.note_box(mk_box(box_if.center_x, box_if.center_y, box_if.center_z,
                                   box_if.half_x, box_if.half_y, box_if.half_z));
                progress = 1'b1;
            end
            if (vis_if.valid && vis_if.ready) begin
                sb.check_visibility(vis_if.visibility);
                progress = 1'b1;
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog on stretches with no accepted request at all.
    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Timeout: no request accepted for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus: one phase per plane setting.
    initial begin : stimulus
        logic [PLANE_W-1:0] extremes [PLANES];
        i_rst_n         = 1'b0;
        box_if.valid    = 1'b0;
        box_if.center_x = '0;
        box_if.center_y = '0;
        box_if.center_z = '0;
        box_if.half_x   = '0;
        box_if.half_y   = '0;
        box_if.half_z   = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = '0;
        cfg_if.data     = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Planes still at reset: every plane is the zero plane, so all boxes are partial.
        feed_extreme_boxes();
        feed_random(40, 2000, 0, 4000, 800, 100);
        finish_phase();

        // Box-shaped frustum: |x| and |y| up to 100.0, z from 10.0 to 1000.0.
        write_plane(PLANE_NEAR, pack_plane(0, 0, 16384, 160));
        write_plane(PLANE_FAR, pack_plane(0, 0, -16384, -16000));
        write_plane(PLANE_LEFT, pack_plane(16384, 0, 0, -1600));
        write_plane(PLANE_RIGHT, pack_plane(-16384, 0, 0, -1600));
        write_plane(PLANE_BOTTOM, pack_plane(0, 16384, 0, -1600));
        write_plane(PLANE_TOP, pack_plane(0, -16384, 0, -1600));
        close_config();

        // Inside, touching and just past the side planes, beyond far, across near.
        feed_box(mk_box(0, 0, 3200, 16, 16, 16));
        feed_box(mk_box(-1700, 0, 3200, 100, 16, 16));
        feed_box(mk_box(-1701, 0, 3200, 100, 16, 16));
        feed_box(mk_box(-1500, 0, 3200, 100, 16, 16));
        feed_box(mk_box(-1499, 0, 3200, 100, 16, 16));
        feed_box(mk_box(1499, 0, 3200, 100, 16, 16));
        feed_box(mk_box(1701, 0, 3200, 100, 16, 16));
        feed_box(mk_box(0, 0, 20000, 16, 16, 16));
        feed_box(mk_box(0, 0, 160, 16, 16, 16));
        // Outside one plane and straddling another: invisible wins.
        feed_box(mk_box(-1701, 0, 160, 100, 16, 16));
        feed_box(mk_box(0, 0, 0, 32767, 32767, 32767));
        feed_box(mk_box(0, 1601, 3200, 16, 0, 16));
        feed_box(mk_box(0, 1600, 3200, 16, 0, 16));
        feed_box(mk_box(0, -1600, 3200, 16, 0, 16));

        sender_jitter = 1'b1;
        sink_jitter   = 1'b1;
        feed_random(60, 2500, 0, 18000, 800, 20);
        // The result side holds off while boxes keep coming, so the row fills up.
        sender_jitter = 1'b0;
        hold_off_req  = 1'b1;
        feed_random(80, 2500, 0, 18000, 800, 20);
        sender_jitter = 1'b1;
        feed_random(120, 2500, 0, 18000, 800, 20);
        finish_phase();

        // Slanted frustum with unit diagonal side normals; writes past the plane count
        // are mixed in and must leave the planes alone.
        write_plane(PLANE_LEFT, pack_plane(11585, 0, 11585, 0));
        write_plane(PLANE_SPARE6, {$urandom, $urandom});
        write_plane(PLANE_RIGHT, pack_plane(-11585, 0, 11585, 0));
        write_plane(PLANE_BOTTOM, pack_plane(0, 11585, 11585, 0));
        write_plane(PLANE_TOP, pack_plane(0, -11585, 11585, 0));
        write_plane(PLANE_NEAR, pack_plane(0, 0, 16384, 16));
        write_plane(PLANE_FAR, pack_plane(0, 0, -16384, -8000));
        write_plane(PLANE_SPARE7, {$urandom, $urandom});
        close_config();
        feed_random(200, 2000, 0, 9000, 600, 20);
        finish_phase();

        // Extreme register patterns, one per plane.
        extremes[0] = 64'h0000_0000_0000_0000;
        extremes[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        extremes[2] = 64'h8000_8000_8000_8000;
        extremes[3] = 64'h7FFF_7FFF_7FFF_7FFF;
        extremes[4] = 64'h8000_7FFF_8000_7FFF;
        extremes[5] = 64'h7FFF_8000_7FFF_8000;
        for (int p = 0; p < PLANES; p++) write_plane(t_plane_idx'(p), extremes[p]);
        close_config();
        sender_jitter = 1'b0;
        feed_extreme_boxes();
        feed_random(100, 32767, 0, 32767, 32767, 100);
        finish_phase();

        // All extremes moved three planes on, so every plane gets another plane's pattern.
        for (int p = 0; p < PLANES; p++)
            write_plane(t_plane_idx'(p), extremes[(p + 3) % PLANES]);
        close_config();
        sender_jitter = 1'b1;
        feed_random(30, 32767, 0, 32767, 32767, 100);
        finish_phase();

        // Arbitrary bit patterns in every plane.
        for (int p = 0; p < PLANES; p++) write_plane(t_plane_idx'(p), {$urandom, $urandom});
        close_config();
        feed_random(120, 4000, 0, 4000, 2000, 50);
        finish_phase();

        // Let any stray result surface before the verdict.
        repeat (2 * PLANES + 4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
design/fbv_pkg.sv
design/fbv_if.sv
design/fbv_cell.sv
design/frustum_box_visibility_test_top.sv
design/fbv_checker.sv
verif/frustum_box_visibility_test_top_tb.sv
